@@ design/airb_pkg.sv @@
// Shared types and constants for the inverse-affine rectangle bounds block.
`timescale 1ns / 1ps

package airb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IDENTITY = 3'd0,
      REG_COEF_XX  = 3'd1,
      REG_COEF_XY  = 3'd2,
      REG_COEF_YX  = 3'd3,
      REG_COEF_YY  = 3'd4,
      REG_SHIFT_X  = 3'd5,
      REG_SHIFT_Y  = 3'd6
   } csr_idx_type;

   typedef enum logic [5:0] {
      ST_DET  = 6'b000001,
      ST_DMAG = 6'b000010,
      ST_LOAD = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_POST = 6'b010000,
      ST_IDLE = 6'b100000
   } seq_state_type;

endpackage

@@ design/affine_inverse_rect_bounds.sv @@
// Inverse-affine bounding box of an integer rectangle, pipelined per request.
// Accepted requests pass in order through the corner, product, mapped-corner, min/max, offset and output
// registers; throughput one request per cycle while rsp_ready is high and no recomputation runs.
// After reset and after every register write the four inverse coefficients are recomputed one after
// another by a shared bit-serial divider, followed by the translation terms; until both are done no request
// is accepted. Reset is synchronous, active high, and loads identity mode with a unit matrix and zero translation.
`timescale 1ns / 1ps

module affine_inverse_rect_bounds
   import airb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_rect_x,
   input  logic signed [15:0]    req_rect_y,
   input  logic [14:0]           req_rect_w,
   input  logic [14:0]           req_rect_h,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_box_x,
   output logic signed [31:0]    rsp_box_y,
   output logic [30:0]           rsp_box_w,
   output logic [30:0]           rsp_box_h,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int QW   = 32 + 2 * FRAC_BITS;     // full quotient width
   localparam int CNTW = $clog2(QW);
   localparam int TW   = 65;                     // coef * (shift - half)
   localparam int KW   = 67;                     // translation offset
   localparam int PW   = 49;                     // coef * corner coordinate
   localparam int CW   = 50;                     // corner sum
   localparam int BW   = 68;
   localparam int EW   = 51;                     // rounded edge
   localparam longint HALF_L  = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint ONE_L   = 64'sd1 <<< FRAC_BITS;
   localparam logic [63:0] SING_LIM = 64'd1 << (2 * FRAC_BITS - 15);
   localparam logic [CNTW-1:0] CNT_TOP = CNTW'(QW - 1);

   // ---------------- configuration registers ----------------
   logic               id_mode_ff;
   logic signed [31:0] xx_ff, xy_ff, yx_ff, yy_ff, sx_ff, sy_ff;
   logic               csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_mode_ff <= 1'b1;
         xx_ff      <= 32'(ONE_L);
         xy_ff      <= '0;
         yx_ff      <= '0;
         yy_ff      <= 32'(ONE_L);
         sx_ff      <= '0;
         sy_ff      <= '0;
      end else if (csr_wr) begin
         case (csr_idx_type'(csr_index))
            REG_IDENTITY: id_mode_ff <= csr_data[0];
            REG_COEF_XX:  xx_ff <= csr_data;
            REG_COEF_XY:  xy_ff <= csr_data;
            REG_COEF_YX:  yx_ff <= csr_data;
            REG_COEF_YY:  yy_ff <= csr_data;
            REG_SHIFT_X:  sx_ff <= csr_data;
            REG_SHIFT_Y:  sy_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- coefficient sequencer ----------------
   seq_state_type      st_ff, st_in;
   logic signed [63:0] pa_ff, pb_ff;
   logic [63:0]        dmag_ff;
   logic               dneg_ff, sing_ff;
   logic [QW-1:0]      num_ff, quo_ff;
   logic [63:0]        rem_ff;
   logic [CNTW-1:0]    cnt_ff;
   logic [1:0]         cidx_ff;
   logic               qneg_ff;
   logic [1:0]         pstep_ff;
   logic signed [31:0] inv_ff [4];
   logic signed [TW-1:0] tp1_ff, tp2_ff;
   logic signed [KW-1:0] kx_ff, ky_ff;
   logic               rnzx_ff, rnzy_ff;

   logic signed [63:0] d_w;
   logic signed [32:0] e_w;
   logic [31:0]        emag_w;
   logic [64:0]        rem_t;
   logic               qbit;
   logic [QW-1:0]      qfull;
   logic [31:0]        q32;
   logic               qsat;
   logic signed [31:0] inv_res;
   logic signed [31:0] pa_coef, pb_coef;
   logic signed [TW-1:0] q1_w, q2_w;
   logic [FRAC_BITS:0] r_w;
   logic signed [KW-1:0] k_w;

   assign d_w = pa_ff - pb_ff;

   always_comb begin
      case (cidx_ff)
         2'd0:    e_w = 33'(yy_ff);
         2'd1:    e_w = -33'(xy_ff);
         2'd2:    e_w = -33'(yx_ff);
         default: e_w = 33'(xx_ff);
      endcase
      emag_w = e_w[32] ? 32'(-e_w) : 32'(e_w);
   end

   // one quotient bit per cycle, restoring
   assign rem_t = {rem_ff, num_ff[QW-1]};
   assign qbit  = (rem_t >= {1'b0, dmag_ff});
   assign qfull = {quo_ff[QW-2:0], qbit};
   assign q32   = qfull[31:0];
   assign qsat  = (qfull[QW-1:32] != '0);

   always_comb begin
      if (qneg_ff) begin
         if (qsat || q32 > 32'h8000_0000) inv_res = 32'sh8000_0000;
         else inv_res = 32'(-q32);
      end else begin
         if (qsat || q32[31]) inv_res = 32'sh7fff_ffff;
         else inv_res = $signed(q32);
      end
   end

   // translation terms: floor parts summed, fraction carry folded into the offset
   assign pa_coef = (pstep_ff == 2'd0) ? inv_ff[0] : inv_ff[2];
   assign pb_coef = (pstep_ff == 2'd0) ? inv_ff[1] : inv_ff[3];
   assign q1_w    = tp1_ff >>> FRAC_BITS;
   assign q2_w    = tp2_ff >>> FRAC_BITS;
   assign r_w     = {1'b0, tp1_ff[FRAC_BITS-1:0]} + {1'b0, tp2_ff[FRAC_BITS-1:0]};
   assign k_w     = KW'(q1_w) + KW'(q2_w) + KW'(HALF_L) + KW'(r_w[FRAC_BITS]);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_DET:  st_in = ST_DMAG;
         ST_DMAG: st_in = ST_LOAD;
         ST_LOAD: st_in = ST_DIV;
         ST_DIV:  if (cnt_ff == '0) st_in = (cidx_ff == 2'd3) ? ST_POST : ST_LOAD;
         ST_POST: if (pstep_ff == 2'd2) st_in = ST_IDLE;
         ST_IDLE: st_in = ST_IDLE;
         default: st_in = ST_DET;
      endcase
      if (csr_wr) st_in = ST_DET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_DET;
         cidx_ff  <= '0;
         pstep_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_DET) begin
            cidx_ff  <= '0;
            pstep_ff <= '0;
         end
         if (st_ff == ST_DIV && cnt_ff == '0) cidx_ff <= cidx_ff + 2'd1;
         if (st_ff == ST_POST) pstep_ff <= pstep_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_DET: begin
            pa_ff <= 64'(xx_ff) * 64'(yy_ff);
            pb_ff <= 64'(xy_ff) * 64'(yx_ff);
         end
         ST_DMAG: begin
            dneg_ff <= d_w[63];
            dmag_ff <= d_w[63] ? 64'(-d_w) : 64'(d_w);
            sing_ff <= ((d_w[63] ? 64'(-d_w) : 64'(d_w)) < SING_LIM);
         end
         ST_LOAD: begin
            qneg_ff <= e_w[32] ^ dneg_ff;
            num_ff  <= QW'(emag_w) << (2 * FRAC_BITS);
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= CNT_TOP;
         end
         ST_DIV: begin
            rem_ff <= qbit ? 64'(rem_t - {1'b0, dmag_ff}) : 64'(rem_t);
            num_ff <= num_ff << 1;
            quo_ff <= qfull;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) inv_ff[cidx_ff] <= inv_res;
         end
         ST_POST: begin
            tp1_ff <= TW'(pa_coef) * TW'(33'(sx_ff) - 33'(HALF_L));
            tp2_ff <= TW'(pb_coef) * TW'(33'(sy_ff) - 33'(HALF_L));
            if (pstep_ff == 2'd1) begin
               kx_ff   <= k_w;
               rnzx_ff <= (r_w[FRAC_BITS-1:0] != '0);
            end
            if (pstep_ff == 2'd2) begin
               ky_ff   <= k_w;
               rnzy_ff <= (r_w[FRAC_BITS-1:0] != '0);
            end
         end
         default: ;
      endcase
   end

   // ---------------- request pipeline ----------------
   logic [6:1] v_ff;
   logic [6:1] en;

   assign en[6] = ~v_ff[6] | rsp_ready;
   assign en[5] = ~v_ff[5] | en[6];
   assign en[4] = ~v_ff[4] | en[5];
   assign en[3] = ~v_ff[3] | en[4];
   assign en[2] = ~v_ff[2] | en[3];
   assign en[1] = ~v_ff[1] | en[2];
   assign req_ready = en[1] & (st_ff == ST_IDLE);
   assign rsp_valid = v_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= req_valid & req_ready;
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
         if (en[4]) v_ff[4] <= v_ff[3];
         if (en[5]) v_ff[5] <= v_ff[4];
         if (en[6]) v_ff[6] <= v_ff[5];
      end
   end

   // rectangle fields ride along for identity mode
   logic signed [15:0] rx_ff [1:5];
   logic signed [15:0] ry_ff [1:5];
   logic [14:0]        rw_ff [1:5];
   logic [14:0]        rh_ff [1:5];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rx_ff[1] <= req_rect_x;
         ry_ff[1] <= req_rect_y;
         rw_ff[1] <= req_rect_w;
         rh_ff[1] <= req_rect_h;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            rx_ff[k] <= rx_ff[k-1];
            ry_ff[k] <= ry_ff[k-1];
            rw_ff[k] <= rw_ff[k-1];
            rh_ff[k] <= rh_ff[k-1];
         end
      end
   end

   // stage 1: corner coordinates
   logic signed [16:0] xl_ff, xr_ff, yt_ff, yb_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         xl_ff <= 17'(req_rect_x);
         xr_ff <= 17'(req_rect_x) + $signed({2'b00, req_rect_w});
         yt_ff <= 17'(req_rect_y);
         yb_ff <= 17'(req_rect_y) + $signed({2'b00, req_rect_h});
      end
   end

   // stage 2: products
   logic signed [PW-1:0] axl_ff, axr_ff, byt_ff, byb_ff;
   logic signed [PW-1:0] cxl_ff, cxr_ff, dyt_ff, dyb_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         axl_ff <= PW'(inv_ff[0]) * PW'(xl_ff);
         axr_ff <= PW'(inv_ff[0]) * PW'(xr_ff);
         byt_ff <= PW'(inv_ff[1]) * PW'(yt_ff);
         byb_ff <= PW'(inv_ff[1]) * PW'(yb_ff);
         cxl_ff <= PW'(inv_ff[2]) * PW'(xl_ff);
         cxr_ff <= PW'(inv_ff[2]) * PW'(xr_ff);
         dyt_ff <= PW'(inv_ff[3]) * PW'(yt_ff);
         dyb_ff <= PW'(inv_ff[3]) * PW'(yb_ff);
      end
   end

   // stage 3: mapped corners
   logic signed [CW-1:0] cx_ff [4];
   logic signed [CW-1:0] cy_ff [4];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         cx_ff[0] <= CW'(axl_ff) + CW'(byt_ff);
         cx_ff[1] <= CW'(axr_ff) + CW'(byt_ff);
         cx_ff[2] <= CW'(axl_ff) + CW'(byb_ff);
         cx_ff[3] <= CW'(axr_ff) + CW'(byb_ff);
         cy_ff[0] <= CW'(cxl_ff) + CW'(dyt_ff);
         cy_ff[1] <= CW'(cxr_ff) + CW'(dyt_ff);
         cy_ff[2] <= CW'(cxl_ff) + CW'(dyb_ff);
         cy_ff[3] <= CW'(cxr_ff) + CW'(dyb_ff);
      end
   end

   // stage 4: min / max per axis
   logic signed [CW-1:0] lox_ff, hix_ff, loy_ff, hiy_ff;
   logic signed [CW-1:0] mnx_a, mnx_b, mxx_a, mxx_b, mny_a, mny_b, mxy_a, mxy_b;

   always_comb begin
      mnx_a = (cx_ff[1] < cx_ff[0]) ? cx_ff[1] : cx_ff[0];
      mnx_b = (cx_ff[3] < cx_ff[2]) ? cx_ff[3] : cx_ff[2];
      mxx_a = (cx_ff[1] > cx_ff[0]) ? cx_ff[1] : cx_ff[0];
      mxx_b = (cx_ff[3] > cx_ff[2]) ? cx_ff[3] : cx_ff[2];
      mny_a = (cy_ff[1] < cy_ff[0]) ? cy_ff[1] : cy_ff[0];
      mny_b = (cy_ff[3] < cy_ff[2]) ? cy_ff[3] : cy_ff[2];
      mxy_a = (cy_ff[1] > cy_ff[0]) ? cy_ff[1] : cy_ff[0];
      mxy_b = (cy_ff[3] > cy_ff[2]) ? cy_ff[3] : cy_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         lox_ff <= (mnx_b < mnx_a) ? mnx_b : mnx_a;
         hix_ff <= (mxx_b > mxx_a) ? mxx_b : mxx_a;
         loy_ff <= (mny_b < mny_a) ? mny_b : mny_a;
         hiy_ff <= (mxy_b > mxy_a) ? mxy_b : mxy_a;
      end
   end

   // stage 5: offset edge and rounded extents
   logic signed [BW-1:0] bx_ff, by_ff;
   logic signed [EW-1:0] hfx_ff, lfx_ff, hfy_ff, lfy_ff;
   logic signed [EW-1:0] hxe, lxe, hye, lye;

   assign hxe = EW'(hix_ff) + EW'(ONE_L - 64'sd1);
   assign lxe = EW'(lox_ff) - EW'(ONE_L - 64'sd1);
   assign hye = EW'(hiy_ff) + EW'(ONE_L - 64'sd1);
   assign lye = EW'(loy_ff) - EW'(ONE_L - 64'sd1);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         bx_ff  <= BW'(lox_ff) - BW'(kx_ff);
         by_ff  <= BW'(loy_ff) - BW'(ky_ff);
         hfx_ff <= hxe >>> FRAC_BITS;
         lfx_ff <= lxe >>> FRAC_BITS;
         hfy_ff <= hye >>> FRAC_BITS;
         lfy_ff <= lye >>> FRAC_BITS;
      end
   end

   // stage 6: truncate toward zero, floor, saturate, select
   logic signed [BW-1:0]   zx, zy, px, py;
   logic signed [EW:0]     wx, wy;
   logic signed [31:0]     sat_px, sat_py;
   logic [30:0]            sat_wx, sat_wy;

   always_comb begin
      zx = (rnzx_ff && bx_ff >= BW'(1)) ? bx_ff - BW'(1) : bx_ff;
      zy = (rnzy_ff && by_ff >= BW'(1)) ? by_ff - BW'(1) : by_ff;
      px = zx >>> FRAC_BITS;
      py = zy >>> FRAC_BITS;
      if (px > BW'(32'sh7fff_ffff)) sat_px = 32'sh7fff_ffff;
      else if (px < BW'(32'sh8000_0000)) sat_px = 32'sh8000_0000;
      else sat_px = 32'(px);
      if (py > BW'(32'sh7fff_ffff)) sat_py = 32'sh7fff_ffff;
      else if (py < BW'(32'sh8000_0000)) sat_py = 32'sh8000_0000;
      else sat_py = 32'(py);
      wx = (EW+1)'(hfx_ff) - (EW+1)'(lfx_ff);
      wy = (EW+1)'(hfy_ff) - (EW+1)'(lfy_ff);
      if (wx < 0) sat_wx = '0;
      else if (wx > (EW+1)'(32'sh7fff_ffff)) sat_wx = 31'h7fff_ffff;
      else sat_wx = 31'(wx);
      if (wy < 0) sat_wy = '0;
      else if (wy > (EW+1)'(32'sh7fff_ffff)) sat_wy = 31'h7fff_ffff;
      else sat_wy = 31'(wy);
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         if (id_mode_ff) begin
            rsp_box_x <= 32'(rx_ff[5]);
            rsp_box_y <= 32'(ry_ff[5]);
            rsp_box_w <= 31'(rw_ff[5]);
            rsp_box_h <= 31'(rh_ff[5]);
         end else if (sing_ff) begin
            rsp_box_x <= '0;
            rsp_box_y <= '0;
            rsp_box_w <= '0;
            rsp_box_h <= '0;
         end else begin
            rsp_box_x <= sat_px;
            rsp_box_y <= sat_py;
            rsp_box_w <= sat_wx;
            rsp_box_h <= sat_wy;
         end
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE)
      else $error("request accepted while coefficients are being recomputed");

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> st_ff == ST_DET)
      else $error("register write did not restart coefficient computation");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff))
      else $error("sequencer state lost its one-hot encoding");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !id_mode_ff && sing_ff |-> rsp_box_w == '0 && rsp_box_h == '0)
      else $error("singular matrix produced a nonzero box");
`endif

endmodule

@@ test/tb_affine_inverse_rect_bounds.sv @@
// Testbench for the inverse-affine rectangle bounds block: directed and random requests.
`timescale 1ns / 1ps

module tb_affine_inverse_rect_bounds;
   import airb_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 3'd7;
   localparam logic signed [127:0] I32_MAX = 128'sd2147483647;
   localparam logic signed [127:0] I32_MIN = -128'sd2147483648;
   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] box_x;
      logic signed [31:0] box_y;
      logic [30:0]        box_w;
      logic [30:0]        box_h;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [15:0] req_rect_x = '0;
   logic signed [15:0] req_rect_y = '0;
   logic [14:0] req_rect_w = '0;
   logic [14:0] req_rect_h = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_ready, rsp_valid, csr_ready;
   logic signed [31:0] rsp_box_x, rsp_box_y;
   logic [30:0] rsp_box_w, rsp_box_h;

   // shadow copy of the register file
   logic ident_on = 1'b1;
   logic signed [31:0] m_xx = Q_ONE, m_xy = 0, m_yx = 0, m_yy = Q_ONE;
   logic signed [31:0] t_x = 0, t_y = 0;

   box_type expected_boxes[$];
   int   errors = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;

   affine_inverse_rect_bounds uut (.*);

   always #5 clock = ~clock;

   function automatic logic signed [127:0] inverse_coef(logic signed [127:0] e,
                                                        logic signed [127:0] dmag,
                                                        logic dneg);
      logic neg;
      logic signed [127:0] q;
      neg = (e < 0) != dneg;
      q = ((e < 0 ? -e : e) <<< (2 * FB)) / dmag;
      if (neg) return (q > -I32_MIN) ? I32_MIN : -q;
      return (q > I32_MAX) ? I32_MAX : q;
   endfunction

   task automatic map_axis(input logic signed [127:0] a, b, xl, xr, yt, yb, sx, sy,
                           output logic signed [31:0] pos, output logic [30:0] len);
      logic signed [127:0] c[4];
      logic signed [127:0] lo, hi, half, one, p1, p2, q1, q2, r, a0, b0, z, span;
      half = 128'sd1 <<< (FB - 1);
      one  = 128'sd1 <<< FB;
      c[0] = a * xl + b * yt;
      c[1] = a * xr + b * yt;
      c[2] = a * xl + b * yb;
      c[3] = a * xr + b * yb;
      lo = c[0];
      hi = c[0];
      for (int k = 1; k < 4; k++) begin
         if (c[k] < lo) lo = c[k];
         if (c[k] > hi) hi = c[k];
      end
      p1 = a * (sx - half);
      p2 = b * (sy - half);
      q1 = p1 >>> FB;
      q2 = p2 >>> FB;
      r  = (p1 - q1 * one) + (p2 - q2 * one);
      a0 = lo - q1 - q2 - half;
      b0 = a0;
      if (r >= one) begin
         b0 = a0 - 1;
         r  = r - one;
      end
      z = (r != 0 && b0 >= 1) ? b0 - 1 : b0;
      z = z >>> FB;
      pos = (z > I32_MAX) ? I32_MAX[31:0] : (z < I32_MIN) ? I32_MIN[31:0] : z[31:0];
      span = ((hi + one - 1) >>> FB) - ((lo - (one - 1)) >>> FB);
      len = (span < 0) ? '0 : (span > I32_MAX) ? I32_MAX[30:0] : span[30:0];
   endtask

   task automatic predict_bounds(input logic signed [15:0] rx, ry,
                                 input logic [14:0] rw, rh, output box_type bx);
      logic signed [127:0] d, dmag, axx, axy, ayx, ayy, xl, xr, yt, yb;
      logic dneg;
      bx = '0;
      if (ident_on) begin
         bx.box_x = 32'(rx);
         bx.box_y = 32'(ry);
         bx.box_w = 31'(rw);
         bx.box_h = 31'(rh);
         return;
      end
      d = 128'(m_xx) * 128'(m_yy) - 128'(m_xy) * 128'(m_yx);
      dneg = d < 0;
      dmag = dneg ? -d : d;
      if (dmag < (128'sd1 <<< (2 * FB - 15))) return;
      axx = inverse_coef(128'(m_yy), dmag, dneg);
      axy = inverse_coef(-128'(m_xy), dmag, dneg);
      ayx = inverse_coef(-128'(m_yx), dmag, dneg);
      ayy = inverse_coef(128'(m_xx), dmag, dneg);
      xl = 128'(rx);
      xr = 128'(rx) + 128'($signed({1'b0, rw}));
      yt = 128'(ry);
      yb = 128'(ry) + 128'($signed({1'b0, rh}));
      map_axis(axx, axy, xl, xr, yt, yb, 128'(t_x), 128'(t_y), bx.box_x, bx.box_w);
      map_axis(ayx, ayy, xl, xr, yt, yb, 128'(t_x), 128'(t_y), bx.box_y, bx.box_h);
   endtask

   task automatic send_rect(input logic signed [15:0] rx, ry, input logic [14:0] rw, rh);
      box_type bx;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_rect_x <= rx;
      req_rect_y <= ry;
      req_rect_w <= rw;
      req_rect_h <= rh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_bounds(rx, ry, rw, rh, bx);
      expected_boxes.push_back(bx);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_IDENTITY: ident_on = val[0];
         REG_COEF_XX:  m_xx = val;
         REG_COEF_XY:  m_xy = val;
         REG_COEF_YX:  m_yx = val;
         REG_COEF_YY:  m_yy = val;
         REG_SHIFT_X:  t_x = val;
         REG_SHIFT_Y:  t_y = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_matrix(input logic ident, input logic signed [31:0] xx, xy, yx, yy,
                              input logic signed [31:0] sx, sy);
      drain_results();
      write_reg(REG_IDENTITY, {31'd0, ident});
      write_reg(REG_COEF_XX, xx);
      write_reg(REG_COEF_XY, xy);
      write_reg(REG_COEF_YX, yx);
      write_reg(REG_COEF_YY, yy);
      write_reg(REG_SHIFT_X, sx);
      write_reg(REG_SHIFT_Y, sy);
   endtask

   task automatic send_corner_rects();
      send_rect(-16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff);
      send_rect(16'sd32767, 16'sd32767, 15'd0, 15'd0);
      send_rect(16'sd10, -16'sd20, 15'd100, 15'd50);
   endtask

   task automatic test_identity_passthrough();
      send_rect(-16'sd32768, 16'sd32767, 15'd0, 15'h7fff);
      send_rect(16'sd32767, -16'sd32768, 15'h7fff, 15'd0);
      send_rect(16'sd0, 16'sd0, 15'd1, 15'd1);
   endtask

   task automatic test_special_matrices();
      load_matrix(1'b0, Q_ONE, 0, 0, Q_ONE, 0, 0);
      send_corner_rects();
      // positive determinant with a zero xx coefficient and translation
      load_matrix(1'b0, 32'sd0, Q_ONE, -32'sd131072, 32'sd16384, 32'sd98304, -32'sd40000);
      send_corner_rects();
      // determinant of zero, then just below and at the singular threshold
      load_matrix(1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0);
      send_rect(16'sd5, 16'sd5, 15'd5, 15'd5);
      load_matrix(1'b0, 32'sd1, 0, 0, 32'sd131071, 0, 0);
      send_rect(16'sd5, 16'sd5, 15'd5, 15'd5);
      // at the threshold the xx inverse saturates
      load_matrix(1'b0, 32'sd1, 0, 0, 32'sd131072, Q_MAX, Q_MIN);
      send_corner_rects();
      load_matrix(1'b0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      send_corner_rects();
      drain_results();
      write_reg(CSR_IDX_UNUSED, 32'hffffffff);
      send_rect(-16'sd1, 16'sd1, 15'd3, 15'd4);
   endtask

   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(262144)) - 32'sd131072;
         2: return $signed($urandom_range(2048)) - 32'sd1024;
         default: case ($urandom_range(4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 0;
            3: return -Q_ONE;
            default: return Q_ONE;
         endcase
      endcase
   endfunction

   task automatic test_random_traffic();
      logic signed [15:0] rx, ry;
      logic [14:0] rw, rh;
      for (int phase = 0; phase < 24; phase++) begin
         load_matrix($urandom_range(99) < 15, pick_coef(), pick_coef(), pick_coef(),
                     pick_coef(), pick_coef(), pick_coef());
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 55; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         for (int n = 0; n < 72; n++) begin
            if ($urandom_range(1)) begin
               rx = 16'($urandom);
               ry = 16'($urandom);
               rw = 15'($urandom);
               rh = 15'($urandom);
            end else begin
               rx = 16'($urandom_range(2000)) - 16'sd1000;
               ry = 16'($urandom_range(2000)) - 16'sd1000;
               rw = 15'($urandom_range(500));
               rh = 15'($urandom_range(500));
            end
            send_rect(rx, ry, rw, rh);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      box_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_boxes.size() == 0) begin
            $error("result with no request pending");
            errors++;
         end else begin
            want = expected_boxes.pop_front();
            if (rsp_box_x !== want.box_x) begin
               $error("box_x expected %0d got %0d", want.box_x, rsp_box_x);
               errors++;
            end
            if (rsp_box_y !== want.box_y) begin
               $error("box_y expected %0d got %0d", want.box_y, rsp_box_y);
               errors++;
            end
            if (rsp_box_w !== want.box_w) begin
               $error("box_w expected %0d got %0d", want.box_w, rsp_box_w);
               errors++;
            end
            if (rsp_box_h !== want.box_h) begin
               $error("box_h expected %0d got %0d", want.box_h, rsp_box_h);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_identity_passthrough();
      test_special_matrices();
      test_random_traffic();
      drain_results();
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
